/* rtl/setq_pkg.sv */
`default_nettype none

package setq_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_ADJUST = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_TICK   = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXPIRED   = 3'd1,
        ST_NONE      = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_DUPLICATE = 3'd5
    } status_t;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic ins;  // open a slot at the first later entry, shift the tail right
        logic del;  // close the slot at the first hit, shift the tail left
    } cell_ctrl_t;

    localparam int unsigned HANDLE_PORT_BITS = 10;
    localparam int unsigned TIME_PORT_BITS   = 32;

endpackage

`default_nettype wire

/* rtl/setq_cell.sv */
`default_nettype none

module setq_cell #(
    parameter int unsigned TIME_BITS   = 32,
    parameter int unsigned HANDLE_BITS = 10
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire setq_pkg::cell_ctrl_t   ctrl,
    input  wire logic [TIME_BITS-1:0]   key,
    input  wire logic [HANDLE_BITS-1:0] handle_new,
    input  wire logic [TIME_BITS-1:0]   left_exp,
    input  wire logic [HANDLE_BITS-1:0] left_hdl,
    input  wire logic                   left_occ,
    input  wire logic                   left_le,
    input  wire logic [TIME_BITS-1:0]   right_exp,
    input  wire logic [HANDLE_BITS-1:0] right_hdl,
    input  wire logic                   right_occ,
    input  wire logic                   hit_in,
    output logic [TIME_BITS-1:0]        exp,
    output logic [HANDLE_BITS-1:0]      hdl,
    output logic                        occ,
    output logic                        le,
    output logic                        hit_out
);

    logic [TIME_BITS-1:0]   exp_reg;
    logic [TIME_BITS-1:0]   exp_next;
    logic [HANDLE_BITS-1:0] hdl_reg;
    logic [HANDLE_BITS-1:0] hdl_next;
    logic                   occ_reg;
    logic                   occ_next;
    logic                   match;

    assign le      = occ_reg && (exp_reg <= key);
    assign match   = occ_reg && (hdl_reg == handle_new);
    assign hit_out = hit_in || match;

    assign exp = exp_reg;
    assign hdl = hdl_reg;
    assign occ = occ_reg;

    always_comb
    begin
        exp_next = exp_reg;
        hdl_next = hdl_reg;
        occ_next = occ_reg;
        if (ctrl.del && hit_out)
        begin
            // pull the neighbor on the right over the removed entry
            exp_next = right_exp;
            hdl_next = right_hdl;
            occ_next = right_occ;
        end
        else if (ctrl.ins && !le)
        begin
            if (left_le)
            begin
                exp_next = key;
                hdl_next = handle_new;
                occ_next = 1'b1;
            end
            else
            begin
                exp_next = left_exp;
                hdl_next = left_hdl;
                occ_next = left_occ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg <= exp_next;
        hdl_reg <= hdl_next;
    end

endmodule

`default_nettype wire

/* rtl/sorted_expiry_timer_queue.sv */
`default_nettype none

// Sorted timer list of CAPACITY entries held in a row of cells, earliest expiry
// first. Raise start for one cycle while busy is low; the command is taken at
// that edge. Results come back on status/expired_handle/last, each valid for
// exactly one cycle while valid is high; there is no way to stall them, so the
// receiver must take every beat as it comes. Add and delete run a lookup state
// and then an insert or a delete state before the result beat, adjust a lookup,
// a remove pass and then an insert pass over the row, and tick a lookup and then
// a pop state that takes one entry per cycle from the head of the row until the
// next entry is not yet due. Duplicate, full and not-found answers come from the
// lookup alone. busy drops in the cycle the final beat (last high) is shown, so
// the next start may coincide with it.
module sorted_expiry_timer_queue #(
    parameter int unsigned CAPACITY    = 64,
    parameter int unsigned TIME_BITS   = 32,
    parameter int unsigned HANDLE_BITS = 10
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       start,
    output logic                                            busy,
    input  wire logic [1:0]                                 command,
    input  wire logic [setq_pkg::HANDLE_PORT_BITS-1:0]      handle,
    input  wire logic [setq_pkg::TIME_PORT_BITS-1:0]        expire_time,
    input  wire logic [setq_pkg::TIME_PORT_BITS-1:0]        now_time,
    output logic                                            valid,
    output logic [2:0]                                      status,
    output logic [setq_pkg::HANDLE_PORT_BITS-1:0]           expired_handle,
    output logic                                            last
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FIND = 5'b00010,
        S_DEL  = 5'b00100,
        S_INS  = 5'b01000,
        S_POP  = 5'b10000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    setq_pkg::command_t     cmd_reg;
    setq_pkg::command_t     cmd_next;
    logic [HANDLE_BITS-1:0] h_reg;
    logic [HANDLE_BITS-1:0] h_next;
    logic [TIME_BITS-1:0]   t_reg;
    logic [TIME_BITS-1:0]   t_next;
    logic [TIME_BITS-1:0]   now_reg;
    logic [TIME_BITS-1:0]   now_next;

    logic                   valid_reg;
    logic                   valid_next;
    setq_pkg::status_t      status_reg;
    setq_pkg::status_t      status_next;
    logic [HANDLE_BITS-1:0] ehdl_reg;
    logic [HANDLE_BITS-1:0] ehdl_next;
    logic                   last_reg;
    logic                   last_next;

    setq_pkg::cell_ctrl_t   ctrl;
    logic [TIME_BITS-1:0]   key;

    logic [TIME_BITS-1:0]   exp_a [CAPACITY];
    logic [HANDLE_BITS-1:0] hdl_a [CAPACITY];
    logic [CAPACITY-1:0]    occ_v;
    logic [CAPACITY-1:0]    le_v;
    logic [CAPACITY:0]      hit_c;

    logic                   found;
    logic                   full;

    assign key      = (state_reg == S_POP) ? now_reg : t_reg;
    assign hit_c[0] = (state_reg == S_POP);
    assign found    = hit_c[CAPACITY];
    assign full     = occ_v[CAPACITY-1];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [TIME_BITS-1:0]   l_exp;
            logic [HANDLE_BITS-1:0] l_hdl;
            logic                   l_occ;
            logic                   l_le;
            logic [TIME_BITS-1:0]   r_exp;
            logic [HANDLE_BITS-1:0] r_hdl;
            logic                   r_occ;

            if (gi == 0)
            begin : g_head
                assign l_exp = '0;
                assign l_hdl = '0;
                assign l_occ = 1'b0;
                assign l_le  = 1'b1;
            end
            else
            begin : g_body
                assign l_exp = exp_a[gi-1];
                assign l_hdl = hdl_a[gi-1];
                assign l_occ = occ_v[gi-1];
                assign l_le  = le_v[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign r_exp = '0;
                assign r_hdl = '0;
                assign r_occ = 1'b0;
            end
            else
            begin : g_inner
                assign r_exp = exp_a[gi+1];
                assign r_hdl = hdl_a[gi+1];
                assign r_occ = occ_v[gi+1];
            end

            setq_cell #(
                .TIME_BITS   (TIME_BITS),
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key        (key),
                .handle_new (h_reg),
                .left_exp   (l_exp),
                .left_hdl   (l_hdl),
                .left_occ   (l_occ),
                .left_le    (l_le),
                .right_exp  (r_exp),
                .right_hdl  (r_hdl),
                .right_occ  (r_occ),
                .hit_in     (hit_c[gi]),
                .exp        (exp_a[gi]),
                .hdl        (hdl_a[gi]),
                .occ        (occ_v[gi]),
                .le         (le_v[gi]),
                .hit_out    (hit_c[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        h_next      = h_reg;
        t_next      = t_reg;
        now_next    = now_reg;
        valid_next  = 1'b0;
        status_next = status_reg;
        ehdl_next   = '0;
        last_next   = 1'b1;
        ctrl        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = setq_pkg::command_t'(command);
                    h_next     = HANDLE_BITS'(handle);
                    t_next     = TIME_BITS'(expire_time);
                    now_next   = TIME_BITS'(now_time);
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                case (cmd_reg)
                    setq_pkg::CMD_ADD:
                    begin
                        if (found)
                        begin
                            valid_next  = 1'b1;
                            status_next = setq_pkg::ST_DUPLICATE;
                            state_next  = S_IDLE;
                        end
                        else if (full)
                        begin
                            valid_next  = 1'b1;
                            status_next = setq_pkg::ST_FULL;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_INS;
                        end
                    end
                    setq_pkg::CMD_ADJUST, setq_pkg::CMD_DELETE:
                    begin
                        if (!found)
                        begin
                            valid_next  = 1'b1;
                            status_next = setq_pkg::ST_NOT_FOUND;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_DEL;
                        end
                    end
                    default:
                    begin
                        state_next = S_POP;
                    end
                endcase
            end
            S_DEL:
            begin
                ctrl.del = 1'b1;
                if (cmd_reg == setq_pkg::CMD_ADJUST)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    valid_next  = 1'b1;
                    status_next = setq_pkg::ST_OK;
                    state_next  = S_IDLE;
                end
            end
            S_INS:
            begin
                ctrl.ins    = 1'b1;
                valid_next  = 1'b1;
                status_next = setq_pkg::ST_OK;
                state_next  = S_IDLE;
            end
            S_POP:
            begin
                valid_next = 1'b1;
                if (le_v[0])
                begin
                    // pop the head; stop once the next entry is not yet due
                    ctrl.del    = 1'b1;
                    status_next = setq_pkg::ST_EXPIRED;
                    ehdl_next   = hdl_a[0];
                    last_next   = !le_v[1];
                    if (!le_v[1])
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    status_next = setq_pkg::ST_NONE;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        h_reg      <= h_next;
        t_reg      <= t_next;
        now_reg    <= now_next;
        status_reg <= status_next;
        ehdl_reg   <= ehdl_next;
        last_reg   <= last_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign valid          = valid_reg;
    assign status         = status_reg;
    assign expired_handle = setq_pkg::HANDLE_PORT_BITS'(ehdl_reg);
    assign last           = last_reg;

    // Occupied cells always form a run starting at the head.
    a_occ_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_v & (occ_v + 1'b1)) == '0)
        else $error("occupied cells not packed at the head");

    // Only tick pops can give more than one beat per command.
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && status != setq_pkg::ST_EXPIRED) |-> last)
        else $error("non-expiry beat without last");

    // After the final beat the sequencer needs a new start and a lookup.
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last) |=> !valid)
        else $error("beat directly after last");

    // An add never succeeds on a full row.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |-> !full)
        else $error("insert into full row");

endmodule

`default_nettype wire

/* bench/sorted_expiry_timer_queue_tb.sv */
`default_nettype none

module sorted_expiry_timer_queue_tb;
    import setq_pkg::*;

    localparam int unsigned TABLE_DEPTH = 64;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        status_t    status;
        logic [9:0] handle;
        logic       last;
    } timer_beat_t;

    // Sorted timer list kept alongside the block; predicts the beats of each command.
    class timer_list_board;
        logic [31:0]   slot_expiry [TABLE_DEPTH];
        logic [9:0]    slot_handle [TABLE_DEPTH];
        int unsigned   fill;
        timer_beat_t   due_beats [$];
        int unsigned   mismatches;

        function int find_handle(logic [9:0] h);
            for (int i = 0; i < fill; i++)
                if (slot_handle[i] == h)
                    return i;
            return -1;
        endfunction

        function void unlink_slot(int pos);
            for (int i = pos; i + 1 < fill; i++)
            begin
                slot_expiry[i] = slot_expiry[i + 1];
                slot_handle[i] = slot_handle[i + 1];
            end
            fill--;
        endfunction

        // Insert behind every entry with an equal or earlier expiry.
        function void place_sorted(logic [9:0] h, logic [31:0] t);
            int pos;
            pos = 0;
            while (pos < fill && slot_expiry[pos] <= t)
                pos++;
            for (int i = fill; i > pos; i--)
            begin
                slot_expiry[i] = slot_expiry[i - 1];
                slot_handle[i] = slot_handle[i - 1];
            end
            slot_expiry[pos] = t;
            slot_handle[pos] = h;
            fill++;
        endfunction

        function void push_beat(status_t st, logic [9:0] h, logic l);
            timer_beat_t beat;
            beat.status = st;
            beat.handle = h;
            beat.last   = l;
            due_beats.push_back(beat);
        endfunction

        function void note_command(command_t cmd, logic [9:0] h, logic [31:0] t,
                                   logic [31:0] now);
            int pos;
            int popped;
            pos = find_handle(h);
            popped = 0;
            case (cmd)
                CMD_ADD:
                begin
                    if (pos >= 0)
                        push_beat(ST_DUPLICATE, '0, 1'b1);
                    else if (fill >= TABLE_DEPTH)
                        push_beat(ST_FULL, '0, 1'b1);
                    else
                    begin
                        place_sorted(h, t);
                        push_beat(ST_OK, '0, 1'b1);
                    end
                end
                CMD_ADJUST, CMD_DELETE:
                begin
                    if (pos < 0)
                        push_beat(ST_NOT_FOUND, '0, 1'b1);
                    else
                    begin
                        unlink_slot(pos);
                        if (cmd == CMD_ADJUST)
                            place_sorted(h, t);
                        push_beat(ST_OK, '0, 1'b1);
                    end
                end
                default:
                begin
                    while (fill > 0 && slot_expiry[0] <= now)
                    begin
                        push_beat(ST_EXPIRED, slot_handle[0], 1'b0);
                        unlink_slot(0);
                        popped++;
                    end
                    if (popped == 0)
                        push_beat(ST_NONE, '0, 1'b1);
                    else
                        due_beats[due_beats.size() - 1].last = 1'b1;
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] wanted);
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, wanted);
            mismatches++;
        endtask

        task check_beat(logic [2:0] st, logic [9:0] h, logic l);
            timer_beat_t want;
            if (due_beats.size() == 0)
            begin
                report_mismatch("beat with nothing pending, status", 32'(st), '0);
                return;
            end
            want = due_beats.pop_front();
            if (st !== want.status)
                report_mismatch("status", 32'(st), 32'(want.status));
            if (h !== want.handle)
                report_mismatch("expired_handle", 32'(h), 32'(want.handle));
            if (l !== want.last)
                report_mismatch("last", 32'(l), 32'(want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    command_t    command;
    logic [9:0]  handle;
    logic [31:0] expire_time;
    logic [31:0] now_time;
    logic        valid;
    logic [2:0]  status;
    logic [9:0]  expired_handle;
    logic        last;

    timer_list_board board;
    logic [9:0]      handle_pool [16];
    logic [31:0]     clock_sec;
    bit              allow_idle;
    int unsigned     stalled_cycles;

    sorted_expiry_timer_queue #(
        .CAPACITY    (TABLE_DEPTH),
        .TIME_BITS   (32),
        .HANDLE_BITS (10)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .handle         (handle),
        .expire_time    (expire_time),
        .now_time       (now_time),
        .valid          (valid),
        .status         (status),
        .expired_handle (expired_handle),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && valid)
            board.check_beat(status, expired_handle, last);
    end

    // End the run once the block goes quiet for too long.
    initial
    begin
        stalled_cycles = 0;
        wait (rst_n === 1'b1);
        while (stalled_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || valid)
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [9:0] pick_handle(bit prefer_present);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (prefer_present && board.fill > 0 && roll < 60)
            return board.slot_handle[$urandom_range(0, board.fill - 1)];
        if (roll < 90)
            return handle_pool[$urandom_range(0, 15)];
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic logic [31:0] near_expiry();
        if ($urandom_range(0, 99) < 15)
            return 32'($urandom);
        return clock_sec + 32'($urandom_range(0, 50));
    endfunction

    function automatic logic [31:0] next_tick_time();
        if ($urandom_range(0, 99) < 10)
            return 32'($urandom);
        clock_sec = clock_sec + 32'($urandom_range(0, 20));
        return clock_sec;
    endfunction

    function automatic command_t pick_command();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return CMD_ADD;
        if (roll < 60)
            return CMD_ADJUST;
        if (roll < 75)
            return CMD_DELETE;
        return CMD_TICK;
    endfunction

    // If allowed, at random drop start and scramble fields for a burst of idle cycles.
    task automatic maybe_pause();
        int unsigned gap;
        if (!allow_idle || $urandom_range(0, 3) != 0)
            return;
        gap = $urandom_range(1, 18);
        start = 1'b0;
        command = command_t'($urandom_range(0, 3));
        handle = 10'($urandom_range(0, 1023));
        expire_time = 32'($urandom);
        now_time = 32'($urandom);
        repeat (gap) @(negedge clk);
    endtask

    // Called at a falling edge; leaves start high; returns at a falling edge once taken.
    task automatic issue_command(command_t cmd, logic [9:0] h, logic [31:0] t,
                                 logic [31:0] now);
        maybe_pause();
        start = 1'b1;
        command = cmd;
        handle = h;
        expire_time = t;
        now_time = now;
        do
            @(posedge clk);
        while (busy);
        board.note_command(cmd, h, t, now);
        @(negedge clk);
    endtask

    task automatic run_mixed(int unsigned count);
        command_t cmd;
        for (int i = 0; i < count; i++)
        begin
            cmd = pick_command();
            case (cmd)
                CMD_ADD:
                    issue_command(cmd, pick_handle(1'b0), near_expiry(), 32'($urandom));
                CMD_TICK:
                    issue_command(cmd, pick_handle(1'b0), 32'($urandom), next_tick_time());
                default:
                    issue_command(cmd, pick_handle(1'b1), near_expiry(), 32'($urandom));
            endcase
        end
    endtask

    task automatic run_directed();
        issue_command(CMD_TICK,   10'd3,    32'($urandom), 32'h0);
        issue_command(CMD_DELETE, 10'd3,    32'($urandom), 32'($urandom));
        issue_command(CMD_ADJUST, 10'd3,    32'd7,         32'($urandom));
        issue_command(CMD_ADD,    10'd0,    32'h0,         32'($urandom));
        issue_command(CMD_ADD,    10'd1023, 32'hFFFF_FFFF, 32'($urandom));
        issue_command(CMD_ADD,    10'd0,    32'd5,         32'($urandom));
        // equal expiries keep arrival order
        issue_command(CMD_ADD,    10'd10,   32'd100,       32'($urandom));
        issue_command(CMD_ADD,    10'd11,   32'd100,       32'($urandom));
        issue_command(CMD_ADD,    10'd12,   32'd100,       32'($urandom));
        issue_command(CMD_ADJUST, 10'd10,   32'd100,       32'($urandom));
        issue_command(CMD_ADJUST, 10'd12,   32'd50,        32'($urandom));
        issue_command(CMD_ADJUST, 10'd0,    32'd200,       32'($urandom));
        issue_command(CMD_DELETE, 10'd11,   32'($urandom), 32'($urandom));
        issue_command(CMD_TICK,   10'd0,    32'($urandom), 32'd49);
        issue_command(CMD_TICK,   10'd0,    32'($urandom), 32'd100);
        issue_command(CMD_TICK,   10'd0,    32'($urandom), 32'hFFFF_FFFE);
        issue_command(CMD_TICK,   10'd0,    32'($urandom), 32'hFFFF_FFFF);
        issue_command(CMD_TICK,   10'd0,    32'($urandom), 32'hFFFF_FFFF);
        issue_command(CMD_DELETE, 10'd1023, 32'($urandom), 32'($urandom));
    endtask

    // Fill the table, hit it while full, then flush every entry in one tick.
    task automatic run_fill_and_flush();
        int unsigned guard;
        guard = 0;
        while (board.fill < TABLE_DEPTH && guard < 200)
        begin
            issue_command(CMD_ADD, 10'($urandom_range(0, 1023)), near_expiry(),
                          32'($urandom));
            guard++;
        end
        issue_command(CMD_ADJUST, pick_handle(1'b1), near_expiry(), 32'($urandom));
        repeat (3)
            issue_command(CMD_ADD, board.slot_handle[$urandom_range(0, board.fill - 1)],
                          near_expiry(), 32'($urandom));
        repeat (3)
            issue_command(CMD_ADD, 10'($urandom_range(0, 1023)), near_expiry(),
                          32'($urandom));
        issue_command(CMD_TICK, 10'($urandom_range(0, 1023)), 32'($urandom),
                      32'hFFFF_FFFF);
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_ADD;
        handle = '0;
        expire_time = '0;
        now_time = '0;
        allow_idle = 1'b1;
        clock_sec = 32'($urandom);
        foreach (handle_pool[i])
            handle_pool[i] = 10'($urandom_range(0, 1023));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        run_mixed(60);
        run_fill_and_flush();
        allow_idle = 1'b0;
        run_mixed(25);
        start = 1'b0;

        while (board.due_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
